/* sv/nlwc_pkg.sv */
// ----------------------------------------------------------------------------
// nlwc_pkg
// Shared types, character codes and helpers for the numeric literal word
// converter.
// ----------------------------------------------------------------------------
package nlwc_pkg;

	localparam int VALUE_W    = 32;
	localparam int BIN_W      = 8;
	localparam int CHAR_W     = 8;
	localparam int CNT_W      = 8;
	localparam int MAX_BIN    = 8;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [2:0] {
		CLS_HEX  = 3'd0,
		CLS_BIN  = 3'd1,
		CLS_DEC  = 3'd2,
		CLS_NAME = 3'd3,
		CLS_BAD  = 3'd4
	} word_class_t;

	localparam logic [CHAR_W-1:0] CH_DOLLAR  = 8'h24;
	localparam logic [CHAR_W-1:0] CH_AT      = 8'h40;
	localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
	localparam logic [CHAR_W-1:0] CH_HASH    = 8'h23;
	localparam logic [CHAR_W-1:0] CH_UNDER   = 8'h5F;
	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_ONE     = 8'h31;
	localparam logic [CHAR_W-1:0] CH_LOW_X   = 8'h78;
	localparam logic [CHAR_W-1:0] CH_UP_H    = 8'h48;
	localparam logic [CHAR_W-1:0] CH_UP_B    = 8'h42;
	localparam logic [CHAR_W-1:0] CH_UP_D    = 8'h44;

	function automatic logic is_dig(input logic [CHAR_W-1:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic is_xd(input logic [CHAR_W-1:0] c);
		return is_dig(c) || ((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66));
	endfunction

	function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'd32) : c;
	endfunction

	// hex digit value, zero for anything that is not a hex digit
	function automatic logic [3:0] hex_val(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] u;
		u = to_upper(c);
		if (is_dig(c))
			return c[3:0];
		else if ((u >= 8'h41) && (u <= 8'h46))
			return 4'(u - 8'h37);
		else
			return 4'd0;
	endfunction

endpackage

/* sv/numeric_literal_word_converter_unit.sv */
// ----------------------------------------------------------------------------
// numeric_literal_word_converter_unit
// Converts one assembler word, streamed one character per transaction, into
// its class, constant value and error/overflow flags.
// ----------------------------------------------------------------------------
// One character is taken per clock while the input register can advance; a
// last character waits there while a previous result is stalled. The input
// register feeds a single stage of classification and accumulator update
// (hex, binary and decimal running values, one shift-and-add each); on the
// character marked tlast the same stage resolves prefix and suffix rules and
// loads the result register. The output register lets the next word stream in while a result waits.
module numeric_literal_word_converter_unit
	import nlwc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [CHAR_W-1:0]     s_tdata,   // [7:0] char_code
	input  logic                  s_tlast,   // last_of_word
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] value, [32] const_error,
	                                         // [33] overflow, [39:34] zero
	output logic [2:0]            m_tuser    // [2:0] word_class
);

	// input register
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;

	// word state
	logic [CNT_W-1:0]   cnt_q;
	word_class_t        cls_q;
	logic               fxd_q, fzero_q, secx_q;
	logic               xd_q, b01_q, dig_q, nok_q, xd1_q, b011_q, xd2_q;
	logic [VALUE_W-1:0] hex0_q, hex1_q, hex2_q, dec_q;
	logic [BIN_W-1:0]   bin0_q, bin1_q;
	logic               m0_q, m1_q, m2_q, md_q;

	// result register
	logic               out_valid_q;
	word_class_t        out_cls_q;
	logic [VALUE_W-1:0] out_val_q;
	logic               out_err_q, out_ovf_q;

	logic adv;

	// next-state and result logic
	logic               first;
	logic [CHAR_W-1:0]  c, cu;
	logic               c_xd, c_b, c_dg, c_alnum;
	logic [3:0]         hv;
	logic [CNT_W-1:0]   cnt_n;
	word_class_t        cls_n;
	logic               fxd_n, fzero_n, secx_n;
	logic               xd_n, b01_n, dig_n, nok_n, xd1_n, b011_n, xd2_n;
	logic [VALUE_W-1:0] hex0_n, hex1_n, hex2_n, dec_n;
	logic [BIN_W-1:0]   bin0_n, bin1_n;
	logic               m0_n, m1_n, m2_n, md_n;
	logic [VALUE_W+3:0] dec_wide;
	word_class_t        r_cls;
	logic [VALUE_W-1:0] r_val;
	logic               r_err, r_ovf, done;

	assign adv      = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_comb begin
		c       = char_s1;
		cu      = to_upper(c);
		first   = (cnt_q == '0);
		c_xd    = is_xd(c);
		c_b     = (c == CH_ZERO) || (c == CH_ONE);
		c_dg    = is_dig(c);
		c_alnum = is_alpha(c) || c_dg;
		hv      = hex_val(c);

		cnt_n = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

		if (first) begin
			if (c == CH_DOLLAR)
				cls_n = CLS_HEX;
			else if ((c == CH_AT) || (c == CH_PERCENT))
				cls_n = CLS_BIN;
			else if (c_dg)
				cls_n = CLS_DEC;
			else if (is_alpha(c) || (c == CH_UNDER) || (c == CH_HASH))
				cls_n = CLS_NAME;
			else
				cls_n = CLS_BAD;
		end else begin
			cls_n = cls_q;
		end

		fxd_n   = first ? c_xd : fxd_q;
		fzero_n = first ? (c == CH_ZERO) : fzero_q;
		secx_n  = (cnt_q == CNT_W'(1)) ? ((c == CH_LOW_X) && (cls_q != CLS_NAME)) : secx_q;
		nok_n   = nok_q && !(!first && (cls_q == CLS_NAME) && !c_alnum && (c != CH_UNDER));

		xd_n  = xd_q && c_xd;
		b01_n = b01_q && c_b;
		dig_n = dig_q && c_dg;

		hex0_n = {hex0_q[VALUE_W-5:0], hv};
		m0_n   = m0_q || (hex0_q[VALUE_W-1 -: 4] != 4'd0);
		bin0_n = {bin0_q[BIN_W-2:0], (c_b ? c[0] : 1'b0)};
		dec_wide = {1'b0, dec_q, 3'b000} + {3'b000, dec_q, 1'b0}
		         + (VALUE_W+4)'(c_dg ? c[3:0] : 4'd0);
		dec_n  = dec_wide[VALUE_W-1:0];
		md_n   = md_q || (dec_wide[VALUE_W+3:VALUE_W] != 4'd0);

		xd1_n  = xd1_q;
		b011_n = b011_q;
		hex1_n = hex1_q;
		m1_n   = m1_q;
		bin1_n = bin1_q;
		if (!first) begin
			xd1_n  = xd1_q && c_xd;
			b011_n = b011_q && c_b;
			hex1_n = {hex1_q[VALUE_W-5:0], hv};
			m1_n   = m1_q || (hex1_q[VALUE_W-1 -: 4] != 4'd0);
			bin1_n = {bin1_q[BIN_W-2:0], (c_b ? c[0] : 1'b0)};
		end

		xd2_n  = xd2_q;
		hex2_n = hex2_q;
		m2_n   = m2_q;
		if (cnt_q >= CNT_W'(2)) begin
			xd2_n  = xd2_q && c_xd;
			hex2_n = {hex2_q[VALUE_W-5:0], hv};
			m2_n   = m2_q || (hex2_q[VALUE_W-1 -: 4] != 4'd0);
		end

		// word resolution on the last character
		r_cls = cls_n;
		r_val = '0;
		r_err = 1'b0;
		r_ovf = 1'b0;
		done  = 1'b0;
		if ((cls_n == CLS_NAME) && !nok_n) begin
			r_cls = CLS_BAD;
			r_err = 1'b1;
		end else begin
			if (fxd_n && (cnt_n >= CNT_W'(2))) begin
				if ((cnt_n > CNT_W'(2)) && fzero_n && secx_n && xd2_n) begin
					r_cls = CLS_HEX;
					r_val = hex2_n;
					r_ovf = m2_n;
					done  = 1'b1;
				end else if (xd_q && !c_xd) begin
					if (cu == CH_UP_H) begin
						r_cls = CLS_HEX;
						r_val = hex0_q;
						r_ovf = m0_q;
						done  = 1'b1;
					end
				end else if (b01_q && (cu == CH_UP_B)) begin
					r_cls = CLS_BIN;
					done  = 1'b1;
					if (cnt_n > CNT_W'(MAX_BIN + 1))
						r_err = 1'b1;
					else
						r_val = VALUE_W'(bin0_q);
				end else if (dig_q && (cu == CH_UP_D)) begin
					r_cls = CLS_DEC;
					r_val = dec_q;
					r_ovf = md_q;
					done  = 1'b1;
				end
			end
			if (!done) begin
				case (cls_n)
					CLS_HEX: begin
						if ((cnt_n < CNT_W'(2)) || !xd1_n) begin
							r_err = 1'b1;
						end else begin
							r_val = hex1_n;
							r_ovf = m1_n;
						end
					end
					CLS_BIN: begin
						if ((cnt_n < CNT_W'(2)) || (cnt_n > CNT_W'(MAX_BIN + 1)) || !b011_n) begin
							r_err = 1'b1;
						end else begin
							r_val = VALUE_W'(bin1_n);
						end
					end
					CLS_DEC: begin
						if (!dig_n) begin
							r_err = 1'b1;
						end else begin
							r_val = dec_n;
							r_ovf = md_n;
						end
					end
					default: begin
						r_err = 1'b1;
					end
				endcase
			end
		end
		if (r_err) begin
			r_val = '0;
			r_ovf = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			cls_q   <= CLS_BAD;
			fxd_q   <= 1'b0;
			fzero_q <= 1'b0;
			secx_q  <= 1'b0;
			xd_q    <= 1'b1;
			b01_q   <= 1'b1;
			dig_q   <= 1'b1;
			nok_q   <= 1'b1;
			xd1_q   <= 1'b1;
			b011_q  <= 1'b1;
			xd2_q   <= 1'b1;
			hex0_q  <= '0;
			hex1_q  <= '0;
			hex2_q  <= '0;
			dec_q   <= '0;
			bin0_q  <= '0;
			bin1_q  <= '0;
			m0_q    <= 1'b0;
			m1_q    <= 1'b0;
			m2_q    <= 1'b0;
			md_q    <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				cnt_q   <= '0;
				cls_q   <= CLS_BAD;
				fxd_q   <= 1'b0;
				fzero_q <= 1'b0;
				secx_q  <= 1'b0;
				xd_q    <= 1'b1;
				b01_q   <= 1'b1;
				dig_q   <= 1'b1;
				nok_q   <= 1'b1;
				xd1_q   <= 1'b1;
				b011_q  <= 1'b1;
				xd2_q   <= 1'b1;
				hex0_q  <= '0;
				hex1_q  <= '0;
				hex2_q  <= '0;
				dec_q   <= '0;
				bin0_q  <= '0;
				bin1_q  <= '0;
				m0_q    <= 1'b0;
				m1_q    <= 1'b0;
				m2_q    <= 1'b0;
				md_q    <= 1'b0;
			end else begin
				cnt_q   <= cnt_n;
				cls_q   <= cls_n;
				fxd_q   <= fxd_n;
				fzero_q <= fzero_n;
				secx_q  <= secx_n;
				xd_q    <= xd_n;
				b01_q   <= b01_n;
				dig_q   <= dig_n;
				nok_q   <= nok_n;
				xd1_q   <= xd1_n;
				b011_q  <= b011_n;
				xd2_q   <= xd2_n;
				hex0_q  <= hex0_n;
				hex1_q  <= hex1_n;
				hex2_q  <= hex2_n;
				dec_q   <= dec_n;
				bin0_q  <= bin0_n;
				bin1_q  <= bin1_n;
				m0_q    <= m0_n;
				m1_q    <= m1_n;
				m2_q    <= m2_n;
				md_q    <= md_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			out_cls_q <= r_cls;
			out_val_q <= r_val;
			out_err_q <= r_err;
			out_ovf_q <= r_ovf;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_cls_q;
	assign m_tdata  = {(OUT_DATA_W - VALUE_W - 2)'(0), out_ovf_q, out_err_q, out_val_q};

endmodule

/* sv/nlwc_checker.sv */
// ----------------------------------------------------------------------------
// nlwc_checker
// Port-level checks for the numeric literal word converter.
// ----------------------------------------------------------------------------
module nlwc_checker
	import nlwc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  s_tlast,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [2:0]            m_tuser
);

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// an error clears value and overflow
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[32] |-> (m_tdata[31:0] == '0) && !m_tdata[33])
		else $error("error result carries value or overflow");

	// names and invalid words are never constants
	a_name_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tuser == CLS_NAME) || (m_tuser == CLS_BAD)) |-> m_tdata[32])
		else $error("name or invalid word without error");

	// a fresh result follows an accepted last-of-word transaction
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
		else $error("result without a last-of-word transaction");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_DATA_W-1:34] == '0))
		else $error("padding bits not zero");

endmodule

bind numeric_literal_word_converter_unit nlwc_checker u_nlwc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
